// ===== hw/rtl/swsd_pkg.sv =====
package swsd_pkg;

   // register indexes on the csr port
   localparam logic [1:0] REG_HOLDOFF   = 2'd0;
   localparam logic [1:0] REG_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_POSITION  = 2'd2;

   localparam int DEFAULT_WINDOW_DEPTH = 1024;

   localparam logic [15:0] HOLDOFF_RESET   = 16'd4000;
   localparam logic [30:0] THRESHOLD_RESET = 31'd655;
   localparam logic [30:0] THRESHOLD_MAX   = 31'h7FFF_FFFF;

   typedef logic signed [1:0] direction_type;

endpackage

// ===== hw/rtl/swsd_ram.sv =====
module swsd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/sliding_window_sigma_contact_detector.sv =====
// Sliding-window sigma contact detector.
// Input channel req_*: one signed Q16.16 position sample per transaction,
// accepted when req_valid is high and req_stall low. Result channel rsp_*:
// one transaction per sample carrying direction, held flag, new window mean
// and new threshold (nine sigma, saturated to 31 bits).
// csr_*: register writes (holdoff ticks, initial threshold, initial
// position), taken only while no sample is in flight (csr_ready high).
// One sample at a time; the next one is taken once the result has been
// loaded into the output register. Each sample passes through the
// shared bit-serial divider (64 steps for the mean, 64 for the variance),
// the 64-step shift-add multiplier for the squared-deviation update and the
// 32-step digit-pair square root, plus six further steps (RAM read,
// detection, mean, sum update, divider setup, output load).
// The window lives in a RAM with registered read; unwritten entries are
// never used, initial_position stands in until the window has wrapped.
// Reset (synchronous): registers to their defaults, empty window, no
// result pending. A stalled result stays in the output register; the next
// sample is still accepted and waits at its end only if the previous
// result has not yet been taken.
module sliding_window_sigma_contact_detector
   import swsd_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_position_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [1:0]  rsp_contact_direction,
   output logic               rsp_contact_flag,
   output logic signed [31:0] rsp_window_mean,
   output logic [30:0]        rsp_deviation_threshold,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

   localparam int PTR_W = $clog2(WINDOW_DEPTH);
   localparam int DIV_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W = 33 + DIV_W;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);
   localparam logic [DIV_W-1:0] DIVISOR_MEAN = DIV_W'(WINDOW_DEPTH);
   localparam logic [DIV_W-1:0] DIVISOR_VAR = DIV_W'(WINDOW_DEPTH - 1);
   localparam logic signed [DIV_W:0] DEPTH_S = (DIV_W + 1)'(WINDOW_DEPTH);

   localparam logic [5:0] STEP_LAST64 = 6'd63;
   localparam logic [5:0] STEP_LAST32 = 6'd31;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_READ   = 4'd1;
   localparam logic [3:0] ST_DETECT = 4'd2;
   localparam logic [3:0] ST_MDIV   = 4'd3;
   localparam logic [3:0] ST_MEAN   = 4'd4;
   localparam logic [3:0] ST_MUL    = 4'd5;
   localparam logic [3:0] ST_SQADD  = 4'd6;
   localparam logic [3:0] ST_VSET   = 4'd7;
   localparam logic [3:0] ST_VDIV   = 4'd8;
   localparam logic [3:0] ST_SQRT   = 4'd9;
   localparam logic [3:0] ST_FIN    = 4'd10;

   logic [3:0]               state_ff, state_in;
   logic [5:0]               step_ff, step_in;
   logic [15:0]              ticks_ff, ticks_in;
   logic [15:0]              count_ff, count_in;
   logic [30:0]              thr_ff, thr_in;
   logic signed [31:0]       ipos_ff, ipos_in;
   logic [PTR_W-1:0]         ptr_ff, ptr_in;
   logic                     filled_ff, filled_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [31:0]       mean_ff, mean_in;
   logic [63:0]              sq_ff, sq_in;
   logic                     flag_ff, flag_in;
   direction_type            dir_ff, dir_in;
   logic signed [31:0]       x_ff, x_in;
   logic signed [32:0]       diff_ff, diff_in;
   logic signed [32:0]       xo_ff, xo_in;
   logic                     sneg_ff, sneg_in;
   logic [63:0]              dvd_ff, dvd_in;
   logic [DIV_W-1:0]         divisor_ff, divisor_in;
   logic [DIV_W-1:0]         rem_ff, rem_in;
   logic [63:0]              mcand_ff, mcand_in;
   logic [63:0]              mplier_ff, mplier_in;
   logic [63:0]              acc_ff, acc_in;
   logic [63:0]              rad_ff, rad_in;
   logic [31:0]              root_ff, root_in;
   logic [33:0]              srem_ff, srem_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   direction_type            out_dir_ff, out_dir_in;
   logic                     out_flag_ff, out_flag_in;
   logic signed [31:0]       out_mean_ff, out_mean_in;
   logic [30:0]              out_thr_ff, out_thr_in;

   logic                     csr_write;
   logic [31:0]              ram_rd_data;
   logic                     ram_wr_en;
   logic                     ram_rd_en;
   logic signed [31:0]       old_val;
   logic signed [SUM_W-1:0]  sum_new;
   logic signed [SUM_W-1:0]  sum_mag;
   logic signed [32:0]       d_val;
   logic signed [32:0]       thr_s;
   logic [15:0]              count_dec;
   logic [DIV_W:0]           div_trial;
   logic                     div_ge;
   logic [DIV_W-1:0]         div_rem_next;
   logic signed [32:0]       quot33;
   logic signed [32:0]       mn_wide;
   logic signed [31:0]       mn;
   logic signed [34:0]       b_val;
   logic [35:0]              sq_trial;
   logic [35:0]              sq_test;
   logic                     sq_ge;
   logic [34:0]              t9;
   logic                     out_free;

   assign csr_write = csr_valid && csr_ready;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   assign ram_rd_en = (state_ff == ST_READ);
   assign ram_wr_en = (state_ff == ST_DETECT);

   swsd_ram #(
      .WIDTH (32),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ptr_ff),
      .wr_data (x_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   // datapath helpers
   assign old_val   = filled_ff ? $signed(ram_rd_data) : ipos_ff;
   assign sum_new   = sum_ff + SUM_W'(x_ff - 33'(old_val));
   assign sum_mag   = sum_new[SUM_W-1] ? -sum_new : sum_new;
   assign d_val     = 33'(x_ff) - 33'(mean_ff);
   assign thr_s     = $signed({2'b00, thr_ff});
   assign count_dec = count_ff - 16'd1;

   // one restoring division step
   assign div_trial    = {rem_ff, dvd_ff[63]};
   assign div_ge       = div_trial >= {1'b0, divisor_ff};
   assign div_rem_next = div_ge ? DIV_W'(div_trial - {1'b0, divisor_ff})
                                : div_trial[DIV_W-1:0];

   // floored mean from magnitude quotient and remainder
   assign quot33  = $signed(dvd_ff[32:0]);
   assign mn_wide = sneg_ff ? (-quot33 - 33'(rem_ff != '0)) : quot33;
   assign mn      = mn_wide[31:0];
   assign b_val   = 35'(xo_ff) - 35'(mean_ff) - 35'(mn);

   // one digit-pair square root step
   assign sq_trial = {srem_ff, rad_ff[63:62]};
   assign sq_test  = {2'b00, root_ff, 2'b01};
   assign sq_ge    = sq_trial >= sq_test;

   assign t9       = {root_ff, 3'b000} + 35'(root_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      ticks_in     = ticks_ff;
      count_in     = count_ff;
      thr_in       = thr_ff;
      ipos_in      = ipos_ff;
      ptr_in       = ptr_ff;
      filled_in    = filled_ff;
      sum_in       = sum_ff;
      mean_in      = mean_ff;
      sq_in        = sq_ff;
      flag_in      = flag_ff;
      dir_in       = dir_ff;
      x_in         = x_ff;
      diff_in      = diff_ff;
      xo_in        = xo_ff;
      sneg_in      = sneg_ff;
      dvd_in       = dvd_ff;
      divisor_in   = divisor_ff;
      rem_in       = rem_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      acc_in       = acc_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      srem_in      = srem_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_dir_in   = out_dir_ff;
      out_flag_in  = out_flag_ff;
      out_mean_in  = out_mean_ff;
      out_thr_in   = out_thr_ff;

      if (csr_write) begin
         case (csr_index)
            REG_HOLDOFF: begin
               ticks_in = csr_data[15:0];
               count_in = csr_data[15:0];
            end
            REG_THRESHOLD: begin
               thr_in = csr_data[30:0];
            end
            REG_POSITION: begin
               ipos_in   = $signed(csr_data);
               ptr_in    = '0;
               filled_in = 1'b0;
               sum_in    = $signed(csr_data) * DEPTH_S;
               mean_in   = $signed(csr_data);
               sq_in     = '0;
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               x_in     = req_position_sample;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_DETECT;
         end
         ST_DETECT: begin
            dir_in = 2'sd0;
            if (count_ff == ticks_ff) begin
               if (d_val > thr_s) begin
                  dir_in   = 2'sd1;
                  count_in = count_dec;
               end else if (d_val < -thr_s) begin
                  dir_in   = -2'sd1;
                  count_in = count_dec;
                  flag_in  = 1'b1;
               end
            end else if (count_dec == '0) begin
               flag_in  = 1'b0;
               count_in = ticks_ff;
            end else begin
               count_in = count_dec;
            end
            diff_in    = 33'(x_ff) - 33'(old_val);
            xo_in      = 33'(x_ff) + 33'(old_val);
            sum_in     = sum_new;
            sneg_in    = sum_new[SUM_W-1];
            dvd_in     = 64'(unsigned'(sum_mag));
            divisor_in = DIVISOR_MEAN;
            rem_in     = '0;
            step_in    = '0;
            if (ptr_ff == PTR_LAST) begin
               ptr_in    = '0;
               filled_in = 1'b1;
            end else begin
               ptr_in = ptr_ff + PTR_W'(1);
            end
            state_in = ST_MDIV;
         end
         ST_MDIV, ST_VDIV: begin
            rem_in  = div_rem_next;
            dvd_in  = {dvd_ff[62:0], div_ge};
            step_in = step_ff + 6'd1;
            if (step_ff == STEP_LAST64) begin
               step_in = '0;
               if (state_ff == ST_MDIV) begin
                  state_in = ST_MEAN;
               end else begin
                  rad_in   = {dvd_ff[62:0], div_ge};
                  root_in  = '0;
                  srem_in  = '0;
                  state_in = ST_SQRT;
               end
            end
         end
         ST_MEAN: begin
            mean_in   = mn;
            mcand_in  = 64'(diff_ff);
            mplier_in = 64'(b_val);
            acc_in    = '0;
            step_in   = '0;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[62:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[63:1]};
            step_in   = step_ff + 6'd1;
            if (step_ff == STEP_LAST64) begin
               step_in  = '0;
               state_in = ST_SQADD;
            end
         end
         ST_SQADD: begin
            sq_in    = sq_ff + acc_ff;
            state_in = ST_VSET;
         end
         ST_VSET: begin
            // a negative sum counts as zero variance
            dvd_in     = sq_ff[63] ? '0 : sq_ff;
            divisor_in = DIVISOR_VAR;
            rem_in     = '0;
            step_in    = '0;
            state_in   = ST_VDIV;
         end
         ST_SQRT: begin
            if (sq_ge) begin
               srem_in = 34'(sq_trial - sq_test);
               root_in = {root_ff[30:0], 1'b1};
            end else begin
               srem_in = sq_trial[33:0];
               root_in = {root_ff[30:0], 1'b0};
            end
            rad_in  = {rad_ff[61:0], 2'b00};
            step_in = step_ff + 6'd1;
            if (step_ff == STEP_LAST32) begin
               step_in  = '0;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               thr_in       = (t9 > 35'(THRESHOLD_MAX)) ? THRESHOLD_MAX : t9[30:0];
               out_thr_in   = (t9 > 35'(THRESHOLD_MAX)) ? THRESHOLD_MAX : t9[30:0];
               out_dir_in   = dir_ff;
               out_flag_in  = flag_ff;
               out_mean_in  = mean_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         ticks_ff     <= HOLDOFF_RESET;
         count_ff     <= HOLDOFF_RESET;
         thr_ff       <= THRESHOLD_RESET;
         ipos_ff      <= '0;
         ptr_ff       <= '0;
         filled_ff    <= 1'b0;
         sum_ff       <= '0;
         mean_ff      <= '0;
         sq_ff        <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         ticks_ff     <= ticks_in;
         count_ff     <= count_in;
         thr_ff       <= thr_in;
         ipos_ff      <= ipos_in;
         ptr_ff       <= ptr_in;
         filled_ff    <= filled_in;
         sum_ff       <= sum_in;
         mean_ff      <= mean_in;
         sq_ff        <= sq_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dir_ff      <= dir_in;
      x_ff        <= x_in;
      diff_ff     <= diff_in;
      xo_ff       <= xo_in;
      sneg_ff     <= sneg_in;
      dvd_ff      <= dvd_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      acc_ff      <= acc_in;
      rad_ff      <= rad_in;
      root_ff     <= root_in;
      srem_ff     <= srem_in;
      out_dir_ff  <= out_dir_in;
      out_flag_ff <= out_flag_in;
      out_mean_ff <= out_mean_in;
      out_thr_ff  <= out_thr_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_contact_direction   = out_dir_ff;
   assign rsp_contact_flag        = out_flag_ff;
   assign rsp_window_mean         = out_mean_ff;
   assign rsp_deviation_threshold = out_thr_ff;

   // accepted sample always goes to the RAM read first
   a_accept_read : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_READ))
      else $error("accepted sample did not start RAM read");

   // window stays filled unless restarted by an initial_position write
   a_filled_sticky : assert property (@(posedge clock) disable iff (reset)
      (filled_ff && !(csr_write && csr_index == REG_POSITION)) |=> filled_ff)
      else $error("window fill state lost");

   // direction code never takes the unused pattern
   a_dir_code : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |-> (dir_ff != 2'b10))
      else $error("illegal direction code");

   // a new result is only loaded when the output register is free
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> ($stable(out_mean_ff) && $stable(out_thr_ff)))
      else $error("pending result overwritten");

endmodule
